### hdl/xct_pkg.sv
// ----------------------------------------------------------------------------
// xct_pkg - shared types and constants for the XML character tokenizer
// Holds the transaction payload structs, the lexer state and the per-byte
// tagging function.
// ----------------------------------------------------------------------------
`default_nettype none

package xct_pkg;

    // Character codes the lexer looks at.
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [7:0] CH_QUOTE = 8'h22;  // '"'
    localparam logic [7:0] CH_LF    = 8'h0A;  // newline
    localparam logic [7:0] CH_TAB   = 8'h09;  // tab
    localparam logic [7:0] CH_NONE  = 8'h00;  // lookahead past the last byte

    // Token type codes.
    localparam logic [3:0] TOK_OPEN_START  = 4'd0;
    localparam logic [3:0] TOK_CLOSE_START = 4'd1;
    localparam logic [3:0] TOK_TAG_END     = 4'd2;
    localparam logic [3:0] TOK_NAME        = 4'd3;
    localparam logic [3:0] TOK_CONTENT     = 4'd4;
    localparam logic [3:0] TOK_ATTR_NAME   = 4'd5;
    localparam logic [3:0] TOK_ATTR_TEXT   = 4'd6;
    localparam logic [3:0] TOK_EQUALS      = 4'd7;
    localparam logic [3:0] TOK_QUOTE       = 4'd8;

    localparam logic [1:0] LEN_MAX = 2'd3;

    // Depth of the result queue in front of the output port.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_OUTSIDE = 2'd0,
        MODE_TAG     = 2'd1,
        MODE_ATTR    = 2'd2,
        MODE_CONTENT = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] char_in;
        logic       stream_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       kept;
        logic       token_end;
        logic [3:0] token_type;
        logic       run_end;
        logic       stream_end;
    } t_out_item;

    typedef struct packed {
        t_mode      mode;
        logic [1:0] len;
        logic [7:0] first;
    } t_lex_state;

    typedef struct packed {
        t_lex_state st;
        logic       kept;
        logic       emit;
        logic [3:0] ttype;
    } t_tag_res;

    // Tags one byte given its one-character lookahead and returns the
    // result flags together with the updated lexer state.
    function automatic t_tag_res tag_byte(t_lex_state s, logic [7:0] b, logic [7:0] la);
        t_tag_res r;
        logic     single;
        r       = '{st: s, kept: 1'b1, emit: 1'b0, ttype: TOK_OPEN_START};
        single  = 1'b0;
        if (b == CH_LF || b == CH_TAB) begin
            r.kept = 1'b0;
        end else begin
            if (r.st.len == 2'd0) begin
                r.st.first = b;
            end
            if (r.st.len != LEN_MAX) begin
                r.st.len = r.st.len + 2'd1;
            end
            single = (r.st.len == 2'd1);
            unique case (r.st.mode)
                MODE_OUTSIDE: begin
                    if (single && b == CH_LT) begin
                        // A lone '<' ahead of '/' waits so "</" ends next byte.
                        if (la != CH_SLASH) begin
                            r.emit    = 1'b1;
                            r.ttype   = TOK_OPEN_START;
                            r.st.mode = MODE_TAG;
                        end
                    end else if (r.st.len == 2'd2 && r.st.first == CH_LT && b == CH_SLASH) begin
                        r.emit    = 1'b1;
                        r.ttype   = TOK_CLOSE_START;
                        r.st.mode = MODE_TAG;
                    end else if (la == CH_LT) begin
                        r.emit  = 1'b1;
                        r.ttype = TOK_CONTENT;
                    end
                end
                MODE_TAG: begin
                    if (la == CH_GT || la == CH_SPACE) begin
                        r.emit  = 1'b1;
                        r.ttype = TOK_NAME;
                    end else if (single && b == CH_GT) begin
                        r.emit    = 1'b1;
                        r.ttype   = TOK_TAG_END;
                        r.st.mode = MODE_OUTSIDE;
                    end else if (single && b == CH_SPACE) begin
                        r.kept    = 1'b0;
                        r.st.len  = 2'd0;
                        r.st.mode = MODE_ATTR;
                    end
                end
                MODE_ATTR: begin
                    if (la == CH_EQ) begin
                        r.emit  = 1'b1;
                        r.ttype = TOK_ATTR_NAME;
                    end else if (single && b == CH_EQ) begin
                        r.emit  = 1'b1;
                        r.ttype = TOK_EQUALS;
                    end else if (single && b == CH_QUOTE) begin
                        r.emit    = 1'b1;
                        r.ttype   = TOK_QUOTE;
                        r.st.mode = MODE_CONTENT;
                    end
                end
                MODE_CONTENT: begin
                    if (la == CH_QUOTE) begin
                        r.emit  = 1'b1;
                        r.ttype = TOK_ATTR_TEXT;
                    end else if (single && b == CH_QUOTE) begin
                        r.emit    = 1'b1;
                        r.ttype   = TOK_QUOTE;
                        r.st.mode = MODE_TAG;
                    end
                end
            endcase
            if (r.emit) begin
                r.st.len = 2'd0;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/xml_char_tokenizer_top.sv
// ----------------------------------------------------------------------------
// xml_char_tokenizer_top - per-byte tagging for a four-mode XML lexer
// Tags each document byte as kept or dropped and marks token ends and types.
// ----------------------------------------------------------------------------
// The block takes one document byte per cycle and sustains that rate. Each
// byte is held until the next byte arrives, because that byte is its
// lookahead, so the result for a byte appears one input transaction later.
// A transaction without stream_last yields one result for the previously held
// byte (none for a document's first byte); a transaction with stream_last
// yields up to two, the held byte and then the final byte itself, seen with
// a lookahead of zero. run_end marks the last result of each input
// transaction and stream_end the result of the final byte. After the final
// byte the lexer returns to its reset state for the next document. All work
// for a transaction is done in the cycle it is accepted and the results are
// pushed into a four-entry queue; the output port shows the queue head. The
// input ready is high whenever the queue holds at most two results, so one
// transaction per cycle flows as long as the consumer takes one result per
// cycle; the extra result of a document's final byte is absorbed by the queue
// and drains during the next cycle that yields no result.
// ----------------------------------------------------------------------------
`default_nettype none

module xml_char_tokenizer_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire xct_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output xct_pkg::t_out_item     o_out_data
);

    localparam int CntW = $clog2(xct_pkg::QUEUE_DEPTH + 1);

    // Lexer state and the byte waiting for its lookahead.
    xct_pkg::t_lex_state r_state, n_state;
    logic [7:0]          r_held, n_held;
    logic                r_held_valid, n_held_valid;

    // Result queue: entry 0 is always the head, so the output reads a fixed place.
    xct_pkg::t_out_item  r_q [xct_pkg::QUEUE_DEPTH];
    xct_pkg::t_out_item  n_q [xct_pkg::QUEUE_DEPTH];
    logic [CntW-1:0]     r_count, n_count;

    logic                in_acc;
    logic                out_acc;
    xct_pkg::t_tag_res   res_held;
    xct_pkg::t_tag_res   res_last;
    xct_pkg::t_lex_state st_mid;
    xct_pkg::t_out_item  item_held;
    xct_pkg::t_out_item  item_last;
    xct_pkg::t_out_item  item0;
    logic                push0;
    logic                push1;
    logic [CntW-1:0]     base;

    // Room for two results guarantees any transaction can be taken.
    assign o_in_ready  = (r_count <= CntW'(xct_pkg::QUEUE_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_q[0];

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // The held byte is tagged with the incoming byte as lookahead; the final
    // byte of a document is then tagged against the state that leaves behind.
    always_comb begin
        res_held = xct_pkg::tag_byte(r_state, r_held, i_in_data.char_in);
        st_mid   = r_held_valid ? res_held.st : r_state;
        res_last = xct_pkg::tag_byte(st_mid, i_in_data.char_in, xct_pkg::CH_NONE);

        item_held = '{char_out:   r_held,
                      kept:       res_held.kept,
                      token_end:  res_held.emit,
                      token_type: res_held.emit ? res_held.ttype : xct_pkg::TOK_OPEN_START,
                      run_end:    !i_in_data.stream_last,
                      stream_end: 1'b0};
        item_last = '{char_out:   i_in_data.char_in,
                      kept:       res_last.kept,
                      token_end:  res_last.emit,
                      token_type: res_last.emit ? res_last.ttype : xct_pkg::TOK_OPEN_START,
                      run_end:    1'b1,
                      stream_end: 1'b1};

        // First pushed result is the held byte's when there is one.
        push0 = in_acc && (r_held_valid || i_in_data.stream_last);
        push1 = in_acc && r_held_valid && i_in_data.stream_last;
        item0 = r_held_valid ? item_held : item_last;
    end

    // Next lexer state.
    always_comb begin
        n_state      = r_state;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        if (in_acc) begin
            if (i_in_data.stream_last) begin
                n_state      = '{mode: xct_pkg::MODE_OUTSIDE, len: 2'd0, first: 8'd0};
                n_held       = 8'd0;
                n_held_valid = 1'b0;
            end else begin
                n_state      = st_mid;
                n_held       = i_in_data.char_in;
                n_held_valid = 1'b1;
            end
        end
    end

    // Queue update: shift on pop, then write new results behind the survivors.
    always_comb begin
        base    = r_count - CntW'(out_acc);
        n_count = base + CntW'(push0) + CntW'(push1);
        for (int i = 0; i < xct_pkg::QUEUE_DEPTH; i++) begin
            if (out_acc && i < xct_pkg::QUEUE_DEPTH - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (push0 && base == CntW'(i)) begin
                n_q[i] = item0;
            end
            if (push1 && (base + CntW'(1)) == CntW'(i)) begin
                n_q[i] = item_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '{mode: xct_pkg::MODE_OUTSIDE, len: 2'd0, first: 8'd0};
            r_held       <= 8'd0;
            r_held_valid <= 1'b0;
            r_count      <= '0;
        end else begin
            r_state      <= n_state;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(xct_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.stream_last |=>
            !r_held_valid && r_state.mode == xct_pkg::MODE_OUTSIDE && r_state.len == 2'd0)
        else $error("lexer not cleared after final byte");

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in_data.stream_last |=>
            r_held_valid && r_held == $past(i_in_data.char_in))
        else $error("byte not held for lookahead");

    a_stream_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stream_end |-> o_out_data.run_end)
        else $error("final byte result not closing its transaction");

    a_type_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.token_end |->
            o_out_data.token_type == xct_pkg::TOK_OPEN_START)
        else $error("token type set without token end");
`endif

endmodule

`default_nettype wire
